// File: rtl/core/tweq_pkg.sv
`default_nettype none
package tweq_pkg;

  // Table size
  localparam int TABLE_DEPTH = 5;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Field widths
  localparam int ADDR_W   = 10;
  localparam int VAL_W    = 8;
  localparam int TIME_W   = 32;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int STATUS_W = 2;

  // Partial sums: days fit in 9 bits, seconds of day in 17 bits
  localparam int DAYS_W = 9;
  localparam int HMS_W  = 17;

  // Calendar constants
  localparam int SECS_PER_DAY    = 86400;
  localparam int SECS_PER_HOUR   = 3600;
  localparam int SECS_PER_MINUTE = 60;
  localparam int DAYS_PER_MONTH  = 30;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EVICTED  = 2'd3;

  // Request class decided by the front
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ALARM  = 2'd1,
    OP_REJECT = 2'd2
  } op_t;

  // Classified request as it travels through the queue
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  val;
    logic [TIME_W-1:0] due;
  } qent_t;

  // One table slot
  typedef struct packed {
    logic [TIME_W-1:0] due;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  val;
  } slot_t;

endpackage
`default_nettype wire

// File: rtl/core/tweq_front.sv
`default_nettype none
module tweq_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_action,
  input  wire logic [tweq_pkg::ADDR_W-1:0]     in_channel_address,
  input  wire logic [tweq_pkg::VAL_W-1:0]      in_channel_value,
  input  wire logic [tweq_pkg::HOUR_W-1:0]     in_hour,
  input  wire logic [tweq_pkg::MINUTE_W-1:0]   in_minute,
  input  wire logic [tweq_pkg::SECOND_W-1:0]   in_second,
  input  wire logic [tweq_pkg::MONTH_W-1:0]    in_month,
  input  wire logic [tweq_pkg::DAY_W-1:0]      in_day,
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output tweq_pkg::qent_t                      push_data
);

  logic                            s1_v_r, s1_v_nxt;
  logic                            s1_act_r;
  logic [tweq_pkg::ADDR_W-1:0]     s1_addr_r;
  logic [tweq_pkg::VAL_W-1:0]      s1_val_r;
  logic [tweq_pkg::DAYS_W-1:0]     s1_days_r, s1_days_nxt;
  logic [tweq_pkg::HMS_W-1:0]      s1_hms_r, s1_hms_nxt;
  logic                            in_acc;
  logic                            zero_due;

  assign in_ready = !s1_v_r || push_ready;
  assign in_acc   = in_valid && in_ready;

  // Split the due time into days and seconds of day
  always_comb begin
    s1_days_nxt = tweq_pkg::DAYS_W'(in_month) * tweq_pkg::DAYS_W'(tweq_pkg::DAYS_PER_MONTH)
                + tweq_pkg::DAYS_W'(in_day);
    s1_hms_nxt  = tweq_pkg::HMS_W'(in_second)
                + tweq_pkg::HMS_W'(in_minute) * tweq_pkg::HMS_W'(tweq_pkg::SECS_PER_MINUTE)
                + tweq_pkg::HMS_W'(in_hour) * tweq_pkg::HMS_W'(tweq_pkg::SECS_PER_HOUR);
  end

  // Hold the staged request until the queue takes it
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (push_ready) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_act_r  <= in_action;
      s1_addr_r <= in_channel_address;
      s1_val_r  <= in_channel_value;
      s1_days_r <= s1_days_nxt;
      s1_hms_r  <= s1_hms_nxt;
    end
  end

  // Finish the due time and classify the request
  assign zero_due = (s1_days_r == '0) && (s1_hms_r == '0);

  always_comb begin
    push_valid     = s1_v_r;
    push_data.addr = s1_addr_r;
    push_data.val  = s1_val_r;
    push_data.due  = tweq_pkg::TIME_W'(s1_days_r)
                   * tweq_pkg::TIME_W'(tweq_pkg::SECS_PER_DAY)
                   + tweq_pkg::TIME_W'(s1_hms_r);
    if (s1_act_r) begin
      push_data.op = tweq_pkg::OP_ALARM;
    end else if (zero_due) begin
      push_data.op = tweq_pkg::OP_REJECT;
    end else begin
      push_data.op = tweq_pkg::OP_INSERT;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/tweq_queue.sv
`default_nettype none
module tweq_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire tweq_pkg::qent_t   push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output tweq_pkg::qent_t        pop_data
);

  tweq_pkg::qent_t                 ent_r [tweq_pkg::QUEUE_DEPTH];
  logic [tweq_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tweq_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [tweq_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign push_ready = cnt_r != tweq_pkg::QCNT_W'(tweq_pkg::QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/tweq_back.sv
`default_nettype none
module tweq_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           pop_valid,
  output logic                                pop_ready,
  input  wire tweq_pkg::qent_t                pop_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_fired,
  output logic [tweq_pkg::ADDR_W-1:0]         out_fired_address,
  output logic [tweq_pkg::VAL_W-1:0]          out_fired_value,
  output logic [tweq_pkg::TIME_W-1:0]         out_next_alarm_time,
  output logic [tweq_pkg::STATUS_W-1:0]       out_status
);

  localparam int D = tweq_pkg::TABLE_DEPTH;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  tweq_pkg::qent_t                 work_r;
  tweq_pkg::slot_t                 tab_r [D];
  tweq_pkg::slot_t                 tab_nxt [D];
  logic [D-1:0]                    le_r, le_nxt;
  logic [D-1:0]                    eq_r, eq_nxt;
  logic [D-1:0]                    first;
  logic                            replace;
  logic                            found;
  logic                            out_v_r, out_v_nxt;
  logic                            fired_nxt;
  logic [tweq_pkg::STATUS_W-1:0]   status_nxt;
  tweq_pkg::slot_t                 head_slot;
  tweq_pkg::slot_t                 new_slot;

  assign pop_ready = (state_r == S_IDLE) && (!out_v_r || out_ready);
  assign out_valid = out_v_r;

  // Sequence each request through compare and update
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (pop_valid && pop_ready) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Compare the request time against every slot
  always_comb begin
    for (int k = 0; k < D; k++) begin
      le_nxt[k] = (tab_r[k].due == '0) || (work_r.due <= tab_r[k].due);
      eq_nxt[k] = tab_r[k].due == work_r.due;
    end
  end

  // Locate the insertion point from the monotone compare flags
  always_comb begin
    first[0] = le_r[0];
    for (int k = 1; k < D; k++) begin
      first[k] = le_r[k] && !le_r[k-1];
    end
  end

  assign replace   = |(first & eq_r);
  assign found     = le_r[D-1];
  assign head_slot = tab_r[0];

  always_comb begin
    new_slot.due  = work_r.due;
    new_slot.addr = work_r.addr;
    new_slot.val  = work_r.val;
  end

  // Build the next table and the result
  always_comb begin
    for (int k = 0; k < D; k++) begin
      tab_nxt[k] = tab_r[k];
    end
    fired_nxt  = 1'b0;
    status_nxt = tweq_pkg::ST_INSERTED;
    case (work_r.op)
      tweq_pkg::OP_INSERT: begin
        if (!found) begin
          status_nxt = tweq_pkg::ST_REJECTED;
        end else begin
          if (replace) begin
            status_nxt = tweq_pkg::ST_REPLACED;
          end else if (tab_r[D-1].due != '0) begin
            status_nxt = tweq_pkg::ST_EVICTED;
          end
          for (int k = 1; k < D; k++) begin
            if (!replace && le_r[k-1]) begin
              tab_nxt[k] = tab_r[k-1];
            end
          end
          for (int k = 0; k < D; k++) begin
            if (first[k]) begin
              tab_nxt[k] = new_slot;
            end
          end
        end
      end
      tweq_pkg::OP_ALARM: begin
        if (head_slot.due != '0) begin
          fired_nxt = 1'b1;
          for (int k = 1; k < D; k++) begin
            tab_nxt[k-1] = tab_r[k];
          end
          tab_nxt[D-1] = '0;
        end
      end
      tweq_pkg::OP_REJECT: begin
        status_nxt = tweq_pkg::ST_REJECTED;
      end
      default: begin
        status_nxt = tweq_pkg::ST_REJECTED;
      end
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_v_nxt = out_v_r;
    if (state_r == S_UPD) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      for (int k = 0; k < D; k++) begin
        tab_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
      if (state_r == S_UPD) begin
        for (int k = 0; k < D; k++) begin
          tab_r[k] <= tab_nxt[k];
        end
      end
    end
  end

  // Capture request, flags and result payload
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      work_r <= pop_data;
    end
    if (state_r == S_CMP) begin
      le_r <= le_nxt;
      eq_r <= eq_nxt;
    end
    if (state_r == S_UPD) begin
      out_fired           <= fired_nxt;
      out_fired_address   <= fired_nxt ? head_slot.addr : '0;
      out_fired_value     <= fired_nxt ? head_slot.val : '0;
      out_next_alarm_time <= tab_nxt[0].due;
      out_status          <= status_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/timed_write_event_queue_core.sv
// Timed write event queue.
// Input channel (in_valid/in_ready): one request per item. in_action 0 schedules
// a channel write at the due time given by month, day, hour, minute and second;
// in_action 1 reports that the alarm fired and pops the earliest entry.
// Result channel (out_valid/out_ready): exactly one result per request, in order,
// with the popped write (out_fired, address, value), the insert status and the
// due time of the new head entry (zero when the table is empty) for the alarm
// comparator.
// The back end takes one request at a time through slot compare, then table
// update into the result register, before it accepts the next.
// A front stage computes the due time and classifies the request; a two-entry
// queue decouples it from the back end, so requests keep being accepted while a
// result waits. When the receiver stalls, the result register holds and the
// queue fills, after which in_ready drops.
// Reset (rst_n low, synchronous) empties the table, the queue and the result.
`default_nettype none
module timed_write_event_queue_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_action,
  input  wire logic [tweq_pkg::ADDR_W-1:0]    in_channel_address,
  input  wire logic [tweq_pkg::VAL_W-1:0]     in_channel_value,
  input  wire logic [tweq_pkg::HOUR_W-1:0]    in_hour,
  input  wire logic [tweq_pkg::MINUTE_W-1:0]  in_minute,
  input  wire logic [tweq_pkg::SECOND_W-1:0]  in_second,
  input  wire logic [tweq_pkg::MONTH_W-1:0]   in_month,
  input  wire logic [tweq_pkg::DAY_W-1:0]     in_day,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_fired,
  output logic [tweq_pkg::ADDR_W-1:0]         out_fired_address,
  output logic [tweq_pkg::VAL_W-1:0]          out_fired_value,
  output logic [tweq_pkg::TIME_W-1:0]         out_next_alarm_time,
  output logic [tweq_pkg::STATUS_W-1:0]       out_status
);

  logic            push_valid, push_ready;
  tweq_pkg::qent_t push_data;
  logic            pop_valid, pop_ready;
  tweq_pkg::qent_t pop_data;

  // Accept and classify requests
  tweq_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_channel_address (in_channel_address),
    .in_channel_value   (in_channel_value),
    .in_hour            (in_hour),
    .in_minute          (in_minute),
    .in_second          (in_second),
    .in_month           (in_month),
    .in_day             (in_day),
    .push_valid         (push_valid),
    .push_ready         (push_ready),
    .push_data          (push_data)
  );

  // Buffer classified requests
  tweq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Update the table and produce results
  tweq_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_data            (pop_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_fired           (out_fired),
    .out_fired_address   (out_fired_address),
    .out_fired_value     (out_fired_value),
    .out_next_alarm_time (out_next_alarm_time),
    .out_status          (out_status)
  );

endmodule
`default_nettype wire

// File: test/tb_top.sv
module tb_top;
  import tweq_pkg::*;

  // Action codes of the input request
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_ALARM  = 1'b1;

  localparam int RANDOM_ITEMS = 1350;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic                action;
    logic [ADDR_W-1:0]   channel_address;
    logic [VAL_W-1:0]    channel_value;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
  } sched_req_t;

  typedef struct {
    logic                fired;
    logic [ADDR_W-1:0]   fired_address;
    logic [VAL_W-1:0]    fired_value;
    logic [TIME_W-1:0]   next_alarm_time;
    logic [STATUS_W-1:0] status;
  } sched_rslt_t;

  typedef struct {
    sched_req_t  req;
    bit          known;
    sched_rslt_t want;
  } dir_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_action = 1'b0;
  logic [ADDR_W-1:0]   in_channel_address = '0;
  logic [VAL_W-1:0]    in_channel_value = '0;
  logic [HOUR_W-1:0]   in_hour = '0;
  logic [MINUTE_W-1:0] in_minute = '0;
  logic [SECOND_W-1:0] in_second = '0;
  logic [MONTH_W-1:0]  in_month = '0;
  logic [DAY_W-1:0]    in_day = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_fired;
  logic [ADDR_W-1:0]   out_fired_address;
  logic [VAL_W-1:0]    out_fired_value;
  logic [TIME_W-1:0]   out_next_alarm_time;
  logic [STATUS_W-1:0] out_status;

  slot_t       sched_tbl [TABLE_DEPTH];
  sched_rslt_t queued_outcomes [$];
  dir_row_t    dir_rows [$];
  int          mismatch_cnt = 0;
  int          n_sent = 0;
  bit          rcv_hold = 1'b0;

  timed_write_event_queue_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_channel_address  (in_channel_address),
    .in_channel_value    (in_channel_value),
    .in_hour             (in_hour),
    .in_minute           (in_minute),
    .in_second           (in_second),
    .in_month            (in_month),
    .in_day              (in_day),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_fired           (out_fired),
    .out_fired_address   (out_fired_address),
    .out_fired_value     (out_fired_value),
    .out_next_alarm_time (out_next_alarm_time),
    .out_status          (out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Convert calendar fields to seconds
  function automatic logic [TIME_W-1:0] due_seconds(sched_req_t r);
    logic [TIME_W-1:0] se, mi, hr, mo, dy;
    se = TIME_W'(r.second);
    mi = TIME_W'(r.minute);
    hr = TIME_W'(r.hour);
    mo = TIME_W'(r.month);
    dy = TIME_W'(r.day);
    return se + mi * SECS_PER_MINUTE + hr * SECS_PER_HOUR
         + (mo * DAYS_PER_MONTH + dy) * SECS_PER_DAY;
  endfunction

  // Apply one request to the shadow table and return its outcome
  function automatic sched_rslt_t step_schedule(sched_req_t r);
    sched_rslt_t       x;
    logic [TIME_W-1:0] t;
    bit                hit;
    x = '{default: '0};
    if (r.action == ACT_INSERT) begin
      t = due_seconds(r);
      x.status = ST_REJECTED;
      hit = 1'b0;
      if (t != '0) begin
        for (int k = 0; k < TABLE_DEPTH && !hit; k++) begin
          if (sched_tbl[k].due == '0) begin
            sched_tbl[k] = '{t, r.channel_address, r.channel_value};
            x.status = ST_INSERTED;
            hit = 1'b1;
          end else if (t == sched_tbl[k].due) begin
            sched_tbl[k] = '{t, r.channel_address, r.channel_value};
            x.status = ST_REPLACED;
            hit = 1'b1;
          end else if (t < sched_tbl[k].due) begin
            x.status = (sched_tbl[TABLE_DEPTH-1].due != '0) ? ST_EVICTED : ST_INSERTED;
            for (int j = TABLE_DEPTH - 1; j > k; j--) sched_tbl[j] = sched_tbl[j-1];
            sched_tbl[k] = '{t, r.channel_address, r.channel_value};
            hit = 1'b1;
          end
        end
      end
    end else if (sched_tbl[0].due != '0) begin
      // Pop head and shift the table up
      x.fired = 1'b1;
      x.fired_address = sched_tbl[0].addr;
      x.fired_value = sched_tbl[0].val;
      for (int k = 1; k < TABLE_DEPTH; k++) sched_tbl[k-1] = sched_tbl[k];
      sched_tbl[TABLE_DEPTH-1] = '0;
    end
    x.next_alarm_time = sched_tbl[0].due;
    return x;
  endfunction

  function automatic sched_req_t make_req(logic act, int addr, int val, int hr, int mi,
                                          int se, int mo, int dy);
    sched_req_t r;
    r.action = act;
    r.channel_address = ADDR_W'(addr);
    r.channel_value = VAL_W'(val);
    r.hour = HOUR_W'(hr);
    r.minute = MINUTE_W'(mi);
    r.second = SECOND_W'(se);
    r.month = MONTH_W'(mo);
    r.day = DAY_W'(dy);
    return r;
  endfunction

  function automatic void add_checked(sched_req_t r);
    dir_row_t row;
    row.req = r;
    row.known = 1'b0;
    row.want = '{default: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_known(sched_req_t r, logic f, int fa, int fv,
                                    logic [TIME_W-1:0] nxt, logic [STATUS_W-1:0] st);
    dir_row_t row;
    row.req = r;
    row.known = 1'b1;
    row.want = '{f, ADDR_W'(fa), VAL_W'(fv), nxt, st};
    dir_rows.push_back(row);
  endfunction

  // Draw a random request; most times come from a narrow pool so equal times recur
  function automatic sched_req_t gen_request(int alarm_pct);
    sched_req_t r;
    int         pick;
    r.action = ($urandom_range(0, 99) < alarm_pct) ? ACT_ALARM : ACT_INSERT;
    r.channel_address = ($urandom_range(0, 1)) ? ADDR_W'($urandom_range(0, 1023))
                                               : ADDR_W'($urandom_range(0, 512));
    r.channel_value = VAL_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      r.hour = HOUR_W'($urandom_range(0, 31));
      r.minute = MINUTE_W'($urandom_range(0, 63));
      r.second = SECOND_W'($urandom_range(0, 63));
      r.month = MONTH_W'($urandom_range(0, 15));
      r.day = DAY_W'($urandom_range(0, 31));
    end else if (pick < 8) begin
      r.hour = '0;
      r.minute = MINUTE_W'($urandom_range(0, 1));
      r.second = SECOND_W'($urandom_range(0, 7));
      r.month = '0;
      r.day = '0;
    end else begin
      r.hour = HOUR_W'($urandom_range(0, 23));
      r.minute = MINUTE_W'($urandom_range(0, 59));
      r.second = SECOND_W'($urandom_range(0, 59));
      r.month = MONTH_W'($urandom_range(0, 12));
      r.day = DAY_W'($urandom_range(0, 30));
    end
    return r;
  endfunction

  // Offer one request, hold it until accepted, then queue its outcome
  task automatic send_request(input sched_req_t r, input bit known, input sched_rslt_t want);
    sched_rslt_t pred;
    in_valid <= 1'b1;
    in_action <= r.action;
    in_channel_address <= r.channel_address;
    in_channel_value <= r.channel_value;
    in_hour <= r.hour;
    in_minute <= r.minute;
    in_second <= r.second;
    in_month <= r.month;
    in_day <= r.day;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = step_schedule(r);
    queued_outcomes.push_back(known ? want : pred);
    n_sent++;
  endtask

  // Sender: directed rows, then random bursts, then drain
  initial begin : sender
    sched_req_t  r;
    sched_rslt_t none;
    int          burst_left;
    int          gap;
    int          alarm_pct;
    none = '{default: '0};
    burst_left = 0;
    alarm_pct = 40;
    for (int k = 0; k < TABLE_DEPTH; k++) sched_tbl[k] = '0;

    // Empty table, zero time, bit extremes, equal time
    add_known(make_req(ACT_ALARM, 0, 0, 0, 0, 0, 0, 0), 1'b0, 0, 0, 0, ST_INSERTED);
    add_known(make_req(ACT_INSERT, 1023, 255, 0, 0, 0, 0, 0), 1'b0, 0, 0, 0, ST_REJECTED);
    add_known(make_req(ACT_INSERT, 1023, 255, 31, 63, 63, 15, 31), 1'b0, 0, 0,
              32'd41673843, ST_INSERTED);
    add_known(make_req(ACT_INSERT, 0, 0, 0, 0, 1, 0, 0), 1'b0, 0, 0, 1, ST_INSERTED);
    add_known(make_req(ACT_INSERT, 5, 7, 0, 0, 1, 0, 0), 1'b0, 0, 0, 1, ST_REPLACED);
    // Fill the table, evict, reject, replace in the middle
    add_checked(make_req(ACT_INSERT, 512, 128, 0, 1, 0, 0, 0));
    add_checked(make_req(ACT_INSERT, 1, 1, 1, 0, 0, 0, 0));
    add_checked(make_req(ACT_INSERT, 2, 2, 0, 0, 0, 0, 1));
    add_checked(make_req(ACT_INSERT, 3, 3, 0, 0, 0, 1, 0));
    add_checked(make_req(ACT_INSERT, 512, 255, 23, 59, 59, 12, 30));
    add_checked(make_req(ACT_INSERT, 9, 9, 0, 0, 0, 0, 1));
    // Pop, reinsert at head, drain to empty
    add_checked(make_req(ACT_ALARM, 0, 0, 0, 0, 0, 0, 0));
    add_checked(make_req(ACT_INSERT, 4, 4, 0, 0, 2, 0, 0));
    for (int k = 0; k < TABLE_DEPTH; k++)
      add_checked(make_req(ACT_ALARM, k * 200, k * 50, k, k, k, k, k));
    add_known(make_req(ACT_ALARM, 0, 0, 0, 0, 0, 0, 0), 1'b0, 0, 0, 0, ST_INSERTED);
    add_known(make_req(ACT_ALARM, 1023, 255, 31, 63, 63, 15, 31), 1'b0, 0, 0, 0, ST_INSERTED);
    add_checked(make_req(ACT_INSERT, 512, 0, 23, 59, 59, 12, 30));

    // Hold reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < dir_rows.size() + RANDOM_ITEMS; i++) begin
      if (i >= dir_rows.size()) begin
        // Shift the alarm mix now and then so the table both fills and drains
        if ((i - dir_rows.size()) % 100 == 0) begin
          case ($urandom_range(0, 2))
            0: alarm_pct = 20;
            1: alarm_pct = 45;
            default: alarm_pct = 70;
          endcase
        end
        r = gen_request(alarm_pct);
      end
      // Idle between bursts; no gaps while the receiver holds off
      if (burst_left == 0) begin
        gap = (rcv_hold || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        repeat (gap) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      if (i < dir_rows.size())
        send_request(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want);
      else
        send_request(r, 1'b0, none);
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (queued_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Receiver: switch among random stall patterns, with one long hold-off
  initial begin : receiver
    rx_mode_t mode;
    int       span;
    int       period;
    int       phase;
    bit       held;
    mode = RX_OPEN;
    span = 0;
    period = 2;
    phase = 0;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (!held && n_sent >= HOLD_AT) begin
        held = 1'b1;
        rcv_hold = 1'b1;
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
        rcv_hold = 1'b0;
      end
      if (span == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        span = $urandom_range(16, 96);
        period = $urandom_range(2, 8);
      end
      span--;
      phase++;
      case (mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (phase % period == 0);
      endcase
      @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest queued outcome
  always @(posedge clk) begin : check_result
    sched_rslt_t w;
    if (rst_n && out_valid && out_ready) begin
      if (queued_outcomes.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        w = queued_outcomes.pop_front();
        if (out_fired !== w.fired)
          flag_mismatch($sformatf("fired got %0b want %0b", out_fired, w.fired));
        if (out_fired_address !== w.fired_address)
          flag_mismatch($sformatf("fired_address got %0d want %0d",
                                  out_fired_address, w.fired_address));
        if (out_fired_value !== w.fired_value)
          flag_mismatch($sformatf("fired_value got %0d want %0d",
                                  out_fired_value, w.fired_value));
        if (out_next_alarm_time !== w.next_alarm_time)
          flag_mismatch($sformatf("next_alarm_time got %0d want %0d",
                                  out_next_alarm_time, w.next_alarm_time));
        if (out_status !== w.status)
          flag_mismatch($sformatf("status got %0d want %0d", out_status, w.status));
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: timed_write_event_queue_core.f
rtl/core/tweq_pkg.sv
rtl/core/tweq_front.sv
rtl/core/tweq_queue.sv
rtl/core/tweq_back.sv
rtl/core/timed_write_event_queue_core.sv
test/tb_top.sv
